// ===== sv/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// stq_pkg: shared types and constants for the sleep timer queue
// Queue sizing, entry layout and control codes for the cell chain and FSM.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int ID_W        = 8;
    localparam int CNT_W       = 16;
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int RUN_W       = $clog2(MAX_RESULTS + 1);

    localparam logic CMD_SLEEP = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic STATUS_WOKEN    = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [CNT_W-1:0] cnt;
    } t_entry;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT_LEFT,
        CELL_DECREMENT
    } t_cell_op;

    typedef enum logic {
        ST_IDLE,
        ST_RELEASE
    } t_state;

endpackage

// ===== sv/stq_cell.sv =====
// ----------------------------------------------------------------------------
// stq_cell: one slot of the sorted sleep queue
// Holds one entry; inserts, shifts toward the head or counts down on command.
// ----------------------------------------------------------------------------
module stq_cell (
    input  logic            i_clk,
    input  stq_pkg::t_cell_op i_op,
    input  logic            i_occupied,
    input  logic            i_left_keep,
    input  stq_pkg::t_entry i_new,
    input  stq_pkg::t_entry i_left,
    input  stq_pkg::t_entry i_right,
    output stq_pkg::t_entry o_entry,
    output logic            o_keep
);
    import stq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // Stay in place when occupied with a count not above the new one
    assign o_keep  = i_occupied && (r_entry.cnt <= i_new.cnt);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_op)
            CELL_INSERT: begin
                if (!o_keep) begin
                    n_entry = i_left_keep ? i_new : i_left;
                end
            end
            CELL_SHIFT_LEFT: begin
                n_entry = i_right;
            end
            CELL_DECREMENT: begin
                if (r_entry.cnt != '0) begin
                    n_entry.cnt = r_entry.cnt - CNT_W'(1);
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ===== sv/sleep_timer_queue_top.sv =====
// ----------------------------------------------------------------------------
// sleep_timer_queue_top: sleep queue of process ids ordered by remaining ticks
// A chain of cells keeps entries sorted; ticks release due entries in order.
// ----------------------------------------------------------------------------
// Sleep: busy stays low. A rejected sleep (queue full) gives its result in
//   the cycle after the command.
// Tick: busy stays high while the release state emits each due entry and
//   through the final countdown step back to idle; results come one per
//   cycle, set by the single head-of-chain release path.
// Results are strobed for one cycle and cannot be stalled.
// Reset (i_rst_n, synchronous, active low) empties the queue and idles the
//   controller; cell contents are left as they are and only read once written.
// ----------------------------------------------------------------------------
module sleep_timer_queue_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_command,
    input  logic [stq_pkg::ID_W-1:0]  i_proc_id,
    input  logic [stq_pkg::CNT_W-1:0] i_duration,
    output logic                      o_strobe,
    output logic [stq_pkg::ID_W-1:0]  o_woken_id,
    output logic                      o_status,
    output logic                      o_last_of_run
);
    import stq_pkg::*;

    // Controller state
    t_state            r_state;
    t_state            n_state;
    logic [OCC_W-1:0]  r_occupancy;
    logic [OCC_W-1:0]  n_occupancy;
    logic [RUN_W-1:0]  r_run;
    logic [RUN_W-1:0]  n_run;

    // Result registers
    logic              r_strobe;
    logic              n_strobe;
    logic [ID_W-1:0]   r_woken_id;
    logic [ID_W-1:0]   n_woken_id;
    logic              r_status;
    logic              n_status;
    logic              r_last;
    logic              n_last;

    // Chain wiring
    t_cell_op          cell_op;
    t_entry            new_entry;
    t_entry            cells    [QUEUE_DEPTH];
    logic              keep     [QUEUE_DEPTH];
    logic              occupied [QUEUE_DEPTH];

    logic              accept;
    logic              full;
    logic              head_due;
    logic              next_due;

    assign accept        = start && !busy;
    assign busy          = (r_state != ST_IDLE);
    assign full          = (r_occupancy >= OCC_W'(QUEUE_DEPTH));
    assign new_entry.id  = i_proc_id;
    assign new_entry.cnt = i_duration;

    // Release the head while it is due and the run limit allows
    assign head_due = (r_occupancy != '0) && (cells[0].cnt <= CNT_W'(1))
                      && (r_run < RUN_W'(MAX_RESULTS));
    // Tell whether the entry behind the head goes out in the same run
    assign next_due = (r_occupancy > OCC_W'(1)) && (cells[1].cnt <= CNT_W'(1))
                      && (r_run < RUN_W'(MAX_RESULTS - 1));

    // ---- cell chain --------------------------------------------------------
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_entry left_entry;
        t_entry right_entry;
        logic   left_keep;

        assign occupied[g] = (r_occupancy > OCC_W'(g));

        if (g == 0) begin : g_head
            // Head takes the new entry whenever it does not keep its own
            assign left_keep  = 1'b1;
            assign left_entry = new_entry;
        end else begin : g_body
            assign left_keep  = keep[g-1];
            assign left_entry = cells[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            // Whatever moves into the tail lies beyond occupancy
            assign right_entry = new_entry;
        end else begin : g_inner
            assign right_entry = cells[g+1];
        end

        stq_cell u_cell (
            .i_clk       (i_clk),
            .i_op        (cell_op),
            .i_occupied  (occupied[g]),
            .i_left_keep (left_keep),
            .i_new       (new_entry),
            .i_left      (left_entry),
            .i_right     (right_entry),
            .o_entry     (cells[g]),
            .o_keep      (keep[g])
        );
    end

    // ---- next state --------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_command == CMD_TICK)) begin
                    n_state = ST_RELEASE;
                end
            end
            ST_RELEASE: begin
                if (!head_due) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ---- outputs and datapath control --------------------------------------
    always_comb begin
        cell_op     = CELL_HOLD;
        n_occupancy = r_occupancy;
        n_run       = r_run;
        n_strobe    = 1'b0;
        n_woken_id  = r_woken_id;
        n_status    = r_status;
        n_last      = r_last;
        case (r_state)
            ST_IDLE: begin
                n_run = '0;
                if (accept && (i_command == CMD_SLEEP)) begin
                    if (full) begin
                        // Drop the entry and report the rejection
                        n_strobe   = 1'b1;
                        n_woken_id = i_proc_id;
                        n_status   = STATUS_REJECTED;
                        n_last     = 1'b1;
                    end else begin
                        cell_op     = CELL_INSERT;
                        n_occupancy = r_occupancy + OCC_W'(1);
                    end
                end
            end
            ST_RELEASE: begin
                if (head_due) begin
                    // Emit the head and advance the chain toward it
                    cell_op     = CELL_SHIFT_LEFT;
                    n_occupancy = r_occupancy - OCC_W'(1);
                    n_run       = r_run + RUN_W'(1);
                    n_strobe    = 1'b1;
                    n_woken_id  = cells[0].id;
                    n_status    = STATUS_WOKEN;
                    n_last      = !next_due;
                end else begin
                    // Count down what is left, then idle
                    cell_op = CELL_DECREMENT;
                end
            end
            default: begin
                cell_op = CELL_HOLD;
            end
        endcase
    end

    // ---- registers ---------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_occupancy <= '0;
            r_run       <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occupancy <= n_occupancy;
            r_run       <= n_run;
            r_strobe    <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_woken_id <= n_woken_id;
        r_status   <= n_status;
        r_last     <= n_last;
    end

    assign o_strobe      = r_strobe;
    assign o_woken_id    = r_woken_id;
    assign o_status      = r_status;
    assign o_last_of_run = r_last;

endmodule

// ===== tb/sv/sleep_timer_queue_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sleep_timer_queue_top_test: self-checking bench for the sleep timer queue
// A directed table walks the corner cases first: empty ticks, zero and
// maximum durations, ties, a full queue with a rejected sleep, and a long
// release run. A random phase follows that alternates between filling and
// draining the queue. Every accepted command runs through a local queue
// model, and every strobed result is checked against the oldest
// expectation.
// ----------------------------------------------------------------------------
module sleep_timer_queue_top_test;

    import stq_pkg::*;

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 286;
    localparam int DRAIN_LIMIT  = 4000;

    // How a transaction's results are checked.
    typedef enum logic [1:0] {
        CHECK_PREDICT,   // results come from the queue model
        CHECK_SILENT,    // typed in: no result at all
        CHECK_ONE        // typed in: exactly one result, last of its run
    } t_check;

    typedef struct {
        logic              cmd;
        logic [ID_W-1:0]   pid;
        logic [CNT_W-1:0]  dur;
        t_check            chk;
        logic [ID_W-1:0]   exp_id;
        logic              exp_status;
    } t_row;

    typedef struct {
        logic [ID_W-1:0] id;
        logic            status;
        logic            last;
    } t_wake;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              start      = 1'b0;
    logic              i_command  = CMD_SLEEP;
    logic [ID_W-1:0]   i_proc_id  = '0;
    logic [CNT_W-1:0]  i_duration = '0;
    logic              busy;
    logic              o_strobe;
    logic [ID_W-1:0]   o_woken_id;
    logic              o_status;
    logic              o_last_of_run;

    // Check mode and typed expectation travel alongside the command.
    t_check            drv_check      = CHECK_PREDICT;
    logic [ID_W-1:0]   drv_exp_id     = '0;
    logic              drv_exp_status = STATUS_WOKEN;

    // Local copy of the queue: sorted by count, ties in insertion order.
    logic [ID_W-1:0]   sleeper_ids    [QUEUE_DEPTH];
    logic [CNT_W-1:0]  sleeper_counts [QUEUE_DEPTH];
    int                sleeper_fill = 0;

    t_wake             pending_wakes[$];
    t_row              stimulus_table[$];
    int                mismatches = 0;
    int                burst_left = 0;

    sleep_timer_queue_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_proc_id     (i_proc_id),
        .i_duration    (i_duration),
        .o_strobe      (o_strobe),
        .o_woken_id    (o_woken_id),
        .o_status      (o_status),
        .o_last_of_run (o_last_of_run)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR %0t: %s got %0h want %0h", $time, what, got, want);
        mismatches++;
    endtask

    // Apply one accepted command to the local queue. Push its wake-ups
    // only when keep is set; typed table rows supply their own.
    task automatic advance_sleep_queue(input logic cmd, input logic [ID_W-1:0] pid,
                                       input logic [CNT_W-1:0] dur, input logic keep);
        int    pos;
        int    due;
        int    j;
        t_wake w;
        if (cmd == CMD_SLEEP) begin
            if (sleeper_fill >= QUEUE_DEPTH) begin
                // Queue full: drop the sleeper and report it back.
                w.id     = pid;
                w.status = STATUS_REJECTED;
                w.last   = 1'b1;
                if (keep) pending_wakes.push_back(w);
            end else begin
                // Slide larger counts back so the newcomer sits behind its equals.
                pos = sleeper_fill;
                while (pos > 0 && sleeper_counts[pos-1] > dur) begin
                    sleeper_ids[pos]    = sleeper_ids[pos-1];
                    sleeper_counts[pos] = sleeper_counts[pos-1];
                    pos--;
                end
                sleeper_ids[pos]    = pid;
                sleeper_counts[pos] = dur;
                sleeper_fill++;
            end
        end else begin
            // Release the front entries whose count is 0 or 1, up to the limit.
            due = 0;
            while (due < sleeper_fill && due < MAX_RESULTS && sleeper_counts[due] <= 1)
                due++;
            for (j = 0; j < due; j++) begin
                w.id     = sleeper_ids[j];
                w.status = STATUS_WOKEN;
                w.last   = (j == due - 1);
                if (keep) pending_wakes.push_back(w);
            end
            for (j = due; j < sleeper_fill; j++) begin
                sleeper_ids[j-due]    = sleeper_ids[j];
                sleeper_counts[j-due] = sleeper_counts[j];
            end
            sleeper_fill -= due;
            // Count down the survivors; an entry held at zero stays at zero.
            for (j = 0; j < sleeper_fill; j++)
                if (sleeper_counts[j] > 0) sleeper_counts[j] = sleeper_counts[j] - 1'b1;
        end
    endtask

    // Result monitor and predictor. Check any strobed result first: it
    // belongs to an earlier transaction than one accepted at this edge.
    always @(posedge i_clk) begin
        t_wake w;
        if (i_rst_n) begin
            if (o_strobe !== 1'b0) begin
                if (pending_wakes.size() == 0) begin
                    report_mismatch("unexpected result, woken_id", o_woken_id, 0);
                end else begin
                    w = pending_wakes.pop_front();
                    if (o_woken_id !== w.id)
                        report_mismatch("woken_id", o_woken_id, w.id);
                    if (o_status !== w.status)
                        report_mismatch("status", o_status, w.status);
                    if (o_last_of_run !== w.last)
                        report_mismatch("last_of_run", o_last_of_run, w.last);
                end
            end
            if (start && !busy) begin
                if (drv_check == CHECK_ONE) begin
                    w.id     = drv_exp_id;
                    w.status = drv_exp_status;
                    w.last   = 1'b1;
                    pending_wakes.push_back(w);
                end
                advance_sleep_queue(i_command, i_proc_id, i_duration,
                                    drv_check == CHECK_PREDICT);
            end
        end
    end

    task automatic add_row(input logic cmd, input logic [ID_W-1:0] pid,
                           input logic [CNT_W-1:0] dur, input t_check chk,
                           input logic [ID_W-1:0] exp_id, input logic exp_status);
        t_row r;
        r.cmd        = cmd;
        r.pid        = pid;
        r.dur        = dur;
        r.chk        = chk;
        r.exp_id     = exp_id;
        r.exp_status = exp_status;
        stimulus_table.push_back(r);
    endtask

    // Sender pacing: bursts of random length, then a random gap. A zero gap
    // keeps start high straight into the next burst.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    // Present one command and hold it until the block takes it.
    task automatic send_command(input t_row r);
        pace_sender();
        i_command      <= r.cmd;
        i_proc_id      <= r.pid;
        i_duration     <= r.dur;
        drv_check      <= r.chk;
        drv_exp_id     <= r.exp_id;
        drv_exp_status <= r.exp_status;
        start          <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    initial begin
        t_row r;
        int   idx;
        int   pick;
        int   tick_odds;
        int   waited;

        // Directed part: empty tick, extremes of id and duration, zero
        // duration ahead of count one, then fill to full with ties, reject
        // one sleeper and release a long run in a single tick.
        add_row(CMD_TICK,  8'h00, 16'h0000, CHECK_SILENT, 8'h00, STATUS_WOKEN);
        add_row(CMD_SLEEP, 8'hFF, 16'h0000, CHECK_SILENT, 8'h00, STATUS_WOKEN);
        add_row(CMD_TICK,  8'h00, 16'h0000, CHECK_ONE,    8'hFF, STATUS_WOKEN);
        add_row(CMD_SLEEP, 8'h00, 16'hFFFF, CHECK_SILENT, 8'h00, STATUS_WOKEN);
        add_row(CMD_SLEEP, 8'hA5, 16'h0001, CHECK_SILENT, 8'h00, STATUS_WOKEN);
        add_row(CMD_SLEEP, 8'h5A, 16'h0000, CHECK_SILENT, 8'h00, STATUS_WOKEN);
        add_row(CMD_TICK,  8'hFF, 16'hFFFF, CHECK_PREDICT, 8'h00, STATUS_WOKEN);
        for (idx = 1; idx <= 15; idx++)
            add_row(CMD_SLEEP, ID_W'(idx), CNT_W'(idx % 2), CHECK_SILENT, 8'h00,
                    STATUS_WOKEN);
        add_row(CMD_SLEEP, 8'hC3, 16'h0002, CHECK_ONE, 8'hC3, STATUS_REJECTED);
        add_row(CMD_TICK,  8'h00, 16'h0000, CHECK_PREDICT, 8'h00, STATUS_WOKEN);

        // Hold reset, then release it on a clock edge.
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stimulus_table[idx]) send_command(stimulus_table[idx]);

        // Random part: alternate fill-heavy and drain-heavy stretches so the
        // queue swings between empty and full. Keep durations mostly short
        // so entries actually wake; let a few long ones clog the queue.
        for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
            tick_odds = ((idx / 40) % 2 == 0) ? 20 : 55;
            r.cmd = ($urandom_range(0, 99) < tick_odds) ? CMD_TICK : CMD_SLEEP;
            r.pid = ID_W'($urandom_range(0, 255));
            pick  = $urandom_range(0, 99);
            if (pick < 65)      r.dur = CNT_W'($urandom_range(0, 3));
            else if (pick < 97) r.dur = CNT_W'($urandom_range(0, 40));
            else                r.dur = CNT_W'($urandom);
            r.chk        = CHECK_PREDICT;
            r.exp_id     = '0;
            r.exp_status = STATUS_WOKEN;
            send_command(r);
        end
        start <= 1'b0;

        // Drain outstanding wake-ups, then idle a little to catch strays.
        waited = 0;
        while (pending_wakes.size() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (2 * MAX_RESULTS + 4) @(posedge i_clk);
        while (pending_wakes.size() > 0) begin
            r.exp_id = pending_wakes[0].id;
            report_mismatch("missing result, woken_id", 0, r.exp_id);
            void'(pending_wakes.pop_front());
        end

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
sv/stq_pkg.sv
sv/stq_cell.sv
sv/sleep_timer_queue_top.sv
tb/sv/sleep_timer_queue_top_test.sv
